@@ rtl/core/tun_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_pkg
// shared constants for the triangle unit normal pipeline
// ----------------------------------------------------------------------------
package tun_pkg;

   localparam int DefCoordWidth = 32;
   localparam int NormBits      = 30;
   localparam int FracOut       = 14;
   localparam int OutWidth      = 16;
   localparam int SqWidth       = 2 * NormBits + 2;
   localparam int RootWidth     = NormBits + 1;
   localparam int DivWidth      = NormBits + FracOut + 1;

endpackage

@@ rtl/core/tun_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_req_if / tun_rsp_if
// valid/ready channels for triangle requests and normal results
// ----------------------------------------------------------------------------
interface tun_req_if #(parameter int COORD_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] left_x, left_y, left_z;
   logic signed [COORD_WIDTH-1:0] mid_x, mid_y, mid_z;
   logic signed [COORD_WIDTH-1:0] right_x, right_y, right_z;
   modport source (output valid, left_x, left_y, left_z, mid_x, mid_y, mid_z,
                   right_x, right_y, right_z, input ready);
   modport sink (input valid, left_x, left_y, left_z, mid_x, mid_y, mid_z,
                 right_x, right_y, right_z, output ready);
endinterface

interface tun_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] norm_x, norm_y, norm_z;
   logic               degenerate;
   modport source (output valid, norm_x, norm_y, norm_z, degenerate, input ready);
   modport sink (input valid, norm_x, norm_y, norm_z, degenerate, output ready);
endinterface

@@ rtl/core/tun_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_core
// pipelined cross product, normalisation, integer square root and division
// ----------------------------------------------------------------------------
module tun_core
   import tun_pkg::*;
#(
   parameter int COORD_WIDTH = DefCoordWidth
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic                          in_valid,
   input  logic signed [COORD_WIDTH-1:0] in_coord [9],
   output logic                          out_valid,
   output logic [OutWidth-1:0]           out_norm [3],
   output logic                          out_degenerate
);

   localparam int DW   = COORD_WIDTH + 1;
   localparam int PW   = 2 * DW;
   localparam int CW   = PW + 1;
   localparam int MW   = CW - 1;
   localparam int LW   = $clog2(MW + 1);
   localparam int NS   = RootWidth;
   localparam int ND   = FracOut + 2;
   localparam int FS   = 6;
   localparam int DEP  = FS + NS + ND + 2;

   // stage 1: differences
   logic signed [DW-1:0] v0_ff [3];
   logic signed [DW-1:0] v1_ff [3];
   // stage 2: products
   logic signed [PW-1:0] p_ff [6];
   // stage 3: cross
   logic signed [CW-1:0] c_ff [3];
   // stage 4: magnitudes and length
   logic [MW-1:0] mg_ff [3];
   logic [2:0]    neg4_ff;
   logic [LW-1:0] bl_ff;
   // stage 5: scaled
   logic [NormBits-1:0] m5_ff [3];
   logic [2:0]          neg5_ff;
   logic                deg5_ff;
   // stage 6: sum of squares
   logic [SqWidth-1:0] s_ff;
   logic [NormBits-1:0] m6_ff [3];
   logic [2:0]          neg6_ff;
   logic                deg6_ff;
   // square root pipeline
   logic [SqWidth-1:0]   rx_ff   [NS+1];
   logic [SqWidth-1:0]   rr_ff   [NS+1];
   logic [NormBits-1:0]  rm_ff   [NS+1][3];
   logic [2:0]           rneg_ff [NS+1];
   logic                 rdeg_ff [NS+1];
   // divider pipeline, restoring, one quotient bit per stage
   logic [DivWidth-1:0]  drem_ff [ND+1][3];
   logic [DivWidth-1:0]  dnum_ff [ND+1][3];
   logic [ND-1:0]        dq_ff   [ND+1][3];
   logic [RootWidth-1:0] dr_ff   [ND+1];
   logic [2:0]           dneg_ff [ND+1];
   logic                 ddeg_ff [ND+1];
   logic [DEP-1:0]       vld_ff;

   logic [MW-1:0]  mg_in [3];
   logic [LW-1:0]  bl_in;
   logic [NormBits-1:0] m5_in [3];

   always_comb begin
      bl_in = '0;
      for (int i = 0; i < 3; i++) begin
         mg_in[i] = c_ff[i][CW-1] ? MW'(-c_ff[i]) : MW'(c_ff[i]);
      end
      for (int b = 0; b < MW; b++) begin
         if ((mg_in[0][b] | mg_in[1][b] | mg_in[2][b]) == 1'b1) begin
            bl_in = LW'(b + 1);
         end
      end
      for (int i = 0; i < 3; i++) begin
         if (bl_ff > LW'(NormBits)) begin
            m5_in[i] = NormBits'(mg_ff[i] >> (bl_ff - LW'(NormBits)));
         end else begin
            m5_in[i] = NormBits'(mg_ff[i] << (LW'(NormBits) - bl_ff));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[DEP-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 3; i++) begin
            v0_ff[i] <= DW'(in_coord[i]) - DW'(in_coord[3+i]);
            v1_ff[i] <= DW'(in_coord[6+i]) - DW'(in_coord[3+i]);
         end
         p_ff[0] <= PW'(v1_ff[1]) * PW'(v0_ff[2]);
         p_ff[1] <= PW'(v1_ff[2]) * PW'(v0_ff[1]);
         p_ff[2] <= PW'(v1_ff[2]) * PW'(v0_ff[0]);
         p_ff[3] <= PW'(v1_ff[0]) * PW'(v0_ff[2]);
         p_ff[4] <= PW'(v1_ff[0]) * PW'(v0_ff[1]);
         p_ff[5] <= PW'(v1_ff[1]) * PW'(v0_ff[0]);
         for (int i = 0; i < 3; i++) begin
            c_ff[i]  <= CW'(p_ff[2*i]) - CW'(p_ff[2*i+1]);
            mg_ff[i] <= mg_in[i];
            neg4_ff[i] <= c_ff[i][CW-1];
            m5_ff[i] <= m5_in[i];
            m6_ff[i] <= m5_ff[i];
         end
         bl_ff   <= bl_in;
         neg5_ff <= neg4_ff;
         deg5_ff <= (bl_ff == '0);
         s_ff <= SqWidth'(m5_ff[0]) * SqWidth'(m5_ff[0])
               + SqWidth'(m5_ff[1]) * SqWidth'(m5_ff[1])
               + SqWidth'(m5_ff[2]) * SqWidth'(m5_ff[2]);
         neg6_ff <= neg5_ff;
         deg6_ff <= deg5_ff;

         rx_ff[0]   <= s_ff;
         rr_ff[0]   <= '0;
         rm_ff[0]   <= m6_ff;
         rneg_ff[0] <= neg6_ff;
         rdeg_ff[0] <= deg6_ff;
         for (int k = 0; k < NS; k++) begin
            logic [SqWidth-1:0] bit_v;
            logic [SqWidth-1:0] trial;
            bit_v = SqWidth'(1) << (2 * (NS - 1 - k));
            trial = rr_ff[k] + bit_v;
            if (rx_ff[k] >= trial) begin
               rx_ff[k+1] <= rx_ff[k] - trial;
               rr_ff[k+1] <= (rr_ff[k] >> 1) + bit_v;
            end else begin
               rx_ff[k+1] <= rx_ff[k];
               rr_ff[k+1] <= rr_ff[k] >> 1;
            end
            rm_ff[k+1]   <= rm_ff[k];
            rneg_ff[k+1] <= rneg_ff[k];
            rdeg_ff[k+1] <= rdeg_ff[k];
         end

         for (int i = 0; i < 3; i++) begin
            logic [DivWidth-1:0] num;
            num = (DivWidth'(rm_ff[NS][i]) << FracOut) + DivWidth'(rr_ff[NS] >> 1);
            drem_ff[0][i] <= num >> ND;
            dnum_ff[0][i] <= num;
            dq_ff[0][i]   <= '0;
         end
         dr_ff[0]   <= rdeg_ff[NS] ? RootWidth'(1) : RootWidth'(rr_ff[NS]);
         dneg_ff[0] <= rneg_ff[NS];
         ddeg_ff[0] <= rdeg_ff[NS];
         for (int k = 0; k < ND; k++) begin
            for (int i = 0; i < 3; i++) begin
               logic [DivWidth-1:0] part;
               part = DivWidth'(dnum_ff[k][i] >> (ND - 1 - k));
               part = (drem_ff[k][i] << 1) | DivWidth'(part[0]);
               if (part >= DivWidth'(dr_ff[k])) begin
                  drem_ff[k+1][i] <= part - DivWidth'(dr_ff[k]);
                  dq_ff[k+1][i]   <= {dq_ff[k][i][ND-2:0], 1'b1};
               end else begin
                  drem_ff[k+1][i] <= part;
                  dq_ff[k+1][i]   <= {dq_ff[k][i][ND-2:0], 1'b0};
               end
               dnum_ff[k+1][i] <= dnum_ff[k][i];
            end
            dr_ff[k+1]   <= dr_ff[k];
            dneg_ff[k+1] <= dneg_ff[k];
            ddeg_ff[k+1] <= ddeg_ff[k];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [OutWidth-1:0] q;
         q = OutWidth'(dq_ff[ND][i]);
         if (dq_ff[ND][i] > ND'(1 << FracOut)) begin
            q = OutWidth'(1 << FracOut);
         end
         if (ddeg_ff[ND]) begin
            out_norm[i] = '0;
         end else begin
            out_norm[i] = dneg_ff[ND][i] ? OutWidth'(-q) : q;
         end
      end
      out_degenerate = ddeg_ff[ND];
      out_valid      = vld_ff[DEP-1];
   end

endmodule

@@ rtl/core/triangle_unit_normal.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_unit_normal
// unit face normal of a triangle, Q16.16 points in, Q2.14 normal out
// ----------------------------------------------------------------------------
// one request per cycle while not stalled; the path is the cross product and
// scaling stages, the one-bit-per-stage square root and divider pipelines and
// an output register. a stall freezes the whole pipeline; the output register
// holds the result so the pipeline keeps moving while it is empty or drained.
module triangle_unit_normal
   import tun_pkg::*;
#(
   parameter int COORD_WIDTH = DefCoordWidth
) (
   input logic          clock,
   input logic          reset,
   tun_req_if.sink      req,
   tun_rsp_if.source    rsp
);

   logic                          enable;
   logic                          core_valid;
   logic [OutWidth-1:0]           core_norm [3];
   logic                          core_degenerate;
   logic signed [COORD_WIDTH-1:0] coord [9];
   logic                          valid_ff;
   logic [OutWidth-1:0]           norm_ff [3];
   logic                          deg_ff;

   assign enable = !valid_ff || rsp.ready;
   assign req.ready = enable;
   assign coord = '{req.left_x, req.left_y, req.left_z, req.mid_x, req.mid_y,
                    req.mid_z, req.right_x, req.right_y, req.right_z};

   tun_core #(.COORD_WIDTH(COORD_WIDTH)) u_core (
      .clock          (clock),
      .reset          (reset),
      .enable         (enable),
      .in_valid       (req.valid),
      .in_coord       (coord),
      .out_valid      (core_valid),
      .out_norm       (core_norm),
      .out_degenerate (core_degenerate)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= core_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         norm_ff <= core_norm;
         deg_ff  <= core_degenerate;
      end
   end

   assign rsp.valid      = valid_ff;
   assign rsp.norm_x     = norm_ff[0];
   assign rsp.norm_y     = norm_ff[1];
   assign rsp.norm_z     = norm_ff[2];
   assign rsp.degenerate = deg_ff;

endmodule
